[rtl/cprg_pkg.sv]
// Shared types, widths and register codes for the camera primary ray generator.
package cprg_pkg;

    // Iterative stage counts of the square root and divider pipelines.
    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 31;

    // Register stages from accepted request to result strobe.
    localparam int FRONT_STAGES = 4;
    localparam int LATENCY = FRONT_STAGES + 2 + SQRT_STAGES + 1 + DIV_STAGES + 1;

    // Unit length in Q1.30 and the common -1 term at scale 2^-47.
    localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
    localparam int          Z_TERM_BIT = 47;

    // Configuration register indexes.
    typedef enum logic [2:0] {
        REG_PROJ_MODE    = 3'd0,
        REG_HALF_FOV_TAN = 3'd1,
        REG_ASPECT       = 3'd2,
        REG_ORTHO_XMAG   = 3'd3,
        REG_ORTHO_YMAG   = 3'd4
    } cfg_index_t;

    // Sign and magnitude of a screen coordinate pair.
    typedef struct packed {
        logic        xneg;
        logic        yneg;
        logic [15:0] xmag;
        logic [15:0] ymag;
    } coord_t;

    // Normalized direction terms that travel with their coordinates.
    typedef struct packed {
        coord_t      c;
        logic [30:0] m0;
        logic [30:0] m1;
        logic [30:0] m2;
    } norm_t;

endpackage

[rtl/cprg_front.sv]
// Front pipeline: screen scaling products and the common normalizing shift.
module cprg_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [15:0]  screen_x,
    input  logic signed [15:0]  screen_y,
    input  logic [23:0]         half_fov_tangent,
    input  logic [23:0]         aspect_ratio,
    output logic                out_valid,
    output cprg_pkg::norm_t     norm
);

    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    cprg_pkg::coord_t   s1_coord_reg, s2_coord_reg, s3_coord_reg;
    cprg_pkg::coord_t   coord_next;
    logic [39:0]        s1_xt_reg, s1_yt_reg;
    logic [63:0]        s2_m0_reg, s3_m0_reg;
    logic [55:0]        s2_m1_reg, s3_m1_reg;
    logic [5:0]         s3_shift_reg;
    logic [5:0]         shift_next;
    logic [63:0]        or_word;
    logic [63:0]        z_term;
    cprg_pkg::norm_t    s4_norm_reg;
    cprg_pkg::norm_t    norm_next;

    // Split the coordinates into sign and magnitude.
    always_comb
    begin
        coord_next.xneg = screen_x[15];
        coord_next.yneg = screen_y[15];
        coord_next.xmag = screen_x[15] ? 16'(-screen_x) : 16'(screen_x);
        coord_next.ymag = screen_y[15] ? 16'(-screen_y) : 16'(screen_y);
    end

    // The largest term decides the shift; the z term always sets bit 47.
    always_comb
    begin
        or_word = s2_m0_reg | {8'b0, s2_m1_reg} | (64'd1 << cprg_pkg::Z_TERM_BIT);
        shift_next = 6'd17;
        for (int i = cprg_pkg::Z_TERM_BIT; i < 63; i++)
        begin
            if (or_word[i])
            begin
                shift_next = 6'(i - 30);
            end
        end
    end

    // Shift all three terms together into 31 bits.
    always_comb
    begin
        z_term = (64'd1 << cprg_pkg::Z_TERM_BIT) >> s3_shift_reg;
        norm_next.c  = s3_coord_reg;
        norm_next.m0 = 31'(s3_m0_reg >> s3_shift_reg);
        norm_next.m1 = 31'(s3_m1_reg >> s3_shift_reg);
        norm_next.m2 = z_term[30:0];
    end

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Payload stages.
    always_ff @(posedge clk)
    begin
        s1_coord_reg <= coord_next;
        s1_xt_reg    <= 40'(coord_next.xmag) * 40'(half_fov_tangent);
        s1_yt_reg    <= 40'(coord_next.ymag) * 40'(half_fov_tangent);
        s2_coord_reg <= s1_coord_reg;
        s2_m0_reg    <= 64'(s1_xt_reg) * 64'(aspect_ratio);
        s2_m1_reg    <= {s1_yt_reg[39:0], 16'b0};
        s3_coord_reg <= s2_coord_reg;
        s3_m0_reg    <= s2_m0_reg;
        s3_m1_reg    <= s2_m1_reg;
        s3_shift_reg <= shift_next;
        s4_norm_reg  <= norm_next;
    end

    assign out_valid = s4_valid_reg;
    assign norm      = s4_norm_reg;

endmodule

[rtl/cprg_isqrt.sv]
// Sum of squares and a pipelined integer square root, one root bit per stage.
module cprg_isqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  cprg_pkg::norm_t  norm_in,
    output logic             out_valid,
    output cprg_pkg::norm_t  norm_out,
    output logic [31:0]      root
);

    localparam int N = cprg_pkg::SQRT_STAGES;

    logic             sq_valid_reg;
    cprg_pkg::norm_t  sq_norm_reg;
    logic [61:0]      sq0_reg, sq1_reg, sq2_reg;

    logic             valid_reg [0:N];
    cprg_pkg::norm_t  side_reg  [0:N];
    logic [63:0]      v_reg     [0:N];
    logic [32:0]      rem_reg   [0:N];
    logic [31:0]      root_reg  [0:N];
    logic [63:0]      v_next    [1:N];
    logic [32:0]      rem_next  [1:N];
    logic [31:0]      root_next [1:N];

    // One radicand digit pair per stage.
    always_comb
    begin
        logic [34:0] cat;
        logic [34:0] trial;
        for (int k = 0; k < N; k++)
        begin
            cat   = {rem_reg[k], v_reg[k][63:62]};
            trial = {1'b0, root_reg[k], 2'b01};
            v_next[k+1] = {v_reg[k][61:0], 2'b00};
            if (cat >= trial)
            begin
                rem_next[k+1]  = 33'(cat - trial);
                root_next[k+1] = {root_reg[k][30:0], 1'b1};
            end
            else
            begin
                rem_next[k+1]  = cat[32:0];
                root_next[k+1] = {root_reg[k][30:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sq_valid_reg <= 1'b0;
            for (int k = 0; k <= N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            sq_valid_reg <= in_valid;
            valid_reg[0] <= sq_valid_reg;
            for (int k = 1; k <= N; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    // Squares, their sum, then the root steps.
    always_ff @(posedge clk)
    begin
        sq_norm_reg <= norm_in;
        sq0_reg     <= 62'(norm_in.m0) * 62'(norm_in.m0);
        sq1_reg     <= 62'(norm_in.m1) * 62'(norm_in.m1);
        sq2_reg     <= 62'(norm_in.m2) * 62'(norm_in.m2);
        side_reg[0] <= sq_norm_reg;
        v_reg[0]    <= 64'(sq0_reg) + 64'(sq1_reg) + 64'(sq2_reg);
        rem_reg[0]  <= 33'd0;
        root_reg[0] <= 32'd0;
        for (int k = 1; k <= N; k++)
        begin
            side_reg[k] <= side_reg[k-1];
            v_reg[k]    <= v_next[k];
            rem_reg[k]  <= rem_next[k];
            root_reg[k] <= root_next[k];
        end
    end

    assign out_valid = valid_reg[N];
    assign norm_out  = side_reg[N];
    assign root      = root_reg[N];

endmodule

[rtl/cprg_div.sv]
// Three-lane pipelined restoring divider that scales the terms by 2^30 over the length.
module cprg_div (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  cprg_pkg::norm_t   norm_in,
    input  logic [31:0]       len,
    output logic              out_valid,
    output cprg_pkg::coord_t  coord,
    output logic [30:0]       q0,
    output logic [30:0]       q1,
    output logic [30:0]       q2
);

    localparam int N = cprg_pkg::DIV_STAGES;

    logic              valid_reg [0:N];
    cprg_pkg::coord_t  coord_reg [0:N];
    logic [31:0]       d_reg     [0:N];
    logic [31:0]       rem_reg   [0:N][0:2];
    logic [30:0]       nlow_reg  [0:N][0:2];
    logic [30:0]       q_reg     [0:N][0:2];
    logic [31:0]       rem_next  [1:N][0:2];
    logic [30:0]       nlow_next [1:N][0:2];
    logic [30:0]       q_next    [1:N][0:2];
    logic [61:0]       num       [0:2];
    logic [30:0]       m_in      [0:2];

    // Rounded numerators: term times 2^30 plus half the length; the sum can carry into bit 61.
    always_comb
    begin
        m_in[0] = norm_in.m0;
        m_in[1] = norm_in.m1;
        m_in[2] = norm_in.m2;
        for (int l = 0; l < 3; l++)
        begin
            num[l] = {1'b0, m_in[l], 30'b0} + 62'(len >> 1);
        end
    end

    // One quotient bit per stage in each lane.
    always_comb
    begin
        logic [32:0] cat;
        for (int k = 0; k < N; k++)
        begin
            for (int l = 0; l < 3; l++)
            begin
                cat = {rem_reg[k][l], nlow_reg[k][l][30]};
                nlow_next[k+1][l] = {nlow_reg[k][l][29:0], 1'b0};
                if (cat >= {1'b0, d_reg[k]})
                begin
                    rem_next[k+1][l] = 32'(cat - {1'b0, d_reg[k]});
                    q_next[k+1][l]   = {q_reg[k][l][29:0], 1'b1};
                end
                else
                begin
                    rem_next[k+1][l] = cat[31:0];
                    q_next[k+1][l]   = {q_reg[k][l][29:0], 1'b0};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k <= N; k++)
            begin
                valid_reg[k] <= 1'b0;
            end
        end
        else
        begin
            valid_reg[0] <= in_valid;
            for (int k = 1; k <= N; k++)
            begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        coord_reg[0] <= norm_in.c;
        d_reg[0]     <= len;
        for (int l = 0; l < 3; l++)
        begin
            rem_reg[0][l]  <= {1'b0, num[l][61:31]};
            nlow_reg[0][l] <= num[l][30:0];
            q_reg[0][l]    <= 31'd0;
        end
        for (int k = 1; k <= N; k++)
        begin
            coord_reg[k] <= coord_reg[k-1];
            d_reg[k]     <= d_reg[k-1];
            for (int l = 0; l < 3; l++)
            begin
                rem_reg[k][l]  <= rem_next[k][l];
                nlow_reg[k][l] <= nlow_next[k][l];
                q_reg[k][l]    <= q_next[k][l];
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign coord     = coord_reg[N];
    assign q0        = q_reg[N][0];
    assign q1        = q_reg[N][1];
    assign q2        = q_reg[N][2];

endmodule

[rtl/camera_primary_ray_gen_core.sv]
// Top level of the camera primary ray generator: registers, pipeline and result stage.
//
// One request (screen_x, screen_y) is taken in every clock cycle; busy is always low.
// Each request yields one ray on the result ports, marked by done for one cycle, after
// the front stages, the 32-stage square root and the 31-stage divider that normalize
// the perspective direction; the result cannot be held off. Registers must be written
// only while no request is in flight; the block itself does not enforce this.
module camera_primary_ray_gen_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic signed [15:0]  screen_x,
    input  logic signed [15:0]  screen_y,
    input  logic                cfg_we,
    input  logic [2:0]          cfg_index,
    input  logic [23:0]         cfg_data,
    output logic                done,
    output logic signed [31:0]  origin_x,
    output logic signed [31:0]  origin_y,
    output logic                origin_z,
    output logic signed [31:0]  dir_x,
    output logic signed [31:0]  dir_y,
    output logic signed [30:0]  dir_z
);

    logic               proj_mode_reg;
    logic [23:0]        half_fov_tan_reg, aspect_reg, ortho_xmag_reg, ortho_ymag_reg;
    logic               front_valid, sqrt_valid, div_valid;
    cprg_pkg::norm_t    front_norm, sqrt_norm;
    logic [31:0]        len;
    cprg_pkg::coord_t   div_coord;
    logic [30:0]        q0, q1, q2;
    logic [30:0]        d0, d1, d2;
    logic [39:0]        ox_prod, oy_prod;
    logic [31:0]        ox_mag, oy_mag;
    logic               done_reg;
    logic [31:0]        origin_x_reg, origin_y_reg, dir_x_reg, dir_y_reg;
    logic [30:0]        dir_z_reg;
    logic [31:0]        origin_x_next, origin_y_next, dir_x_next, dir_y_next;
    logic [30:0]        dir_z_next;

    // Configuration writes; unknown indexes are ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proj_mode_reg    <= 1'b0;
            half_fov_tan_reg <= 24'h01_0000;
            aspect_reg       <= 24'h01_0000;
            ortho_xmag_reg   <= 24'h01_0000;
            ortho_ymag_reg   <= 24'h01_0000;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                cprg_pkg::REG_PROJ_MODE:    proj_mode_reg    <= cfg_data[0];
                cprg_pkg::REG_HALF_FOV_TAN: half_fov_tan_reg <= cfg_data;
                cprg_pkg::REG_ASPECT:       aspect_reg       <= cfg_data;
                cprg_pkg::REG_ORTHO_XMAG:   ortho_xmag_reg   <= cfg_data;
                cprg_pkg::REG_ORTHO_YMAG:   ortho_ymag_reg   <= cfg_data;
                default:                    ;
            endcase
        end
    end

    assign busy = 1'b0;

    cprg_front u_front (
        .clk              (clk),
        .rst_n            (rst_n),
        .in_valid         (start && !busy),
        .screen_x         (screen_x),
        .screen_y         (screen_y),
        .half_fov_tangent (half_fov_tan_reg),
        .aspect_ratio     (aspect_reg),
        .out_valid        (front_valid),
        .norm             (front_norm)
    );

    cprg_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (front_valid),
        .norm_in   (front_norm),
        .out_valid (sqrt_valid),
        .norm_out  (sqrt_norm),
        .root      (len)
    );

    cprg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sqrt_valid),
        .norm_in   (sqrt_norm),
        .len       (len),
        .out_valid (div_valid),
        .coord     (div_coord),
        .q0        (q0),
        .q1        (q1),
        .q2        (q2)
    );

    // Clamp the quotients to unit length.
    assign d0 = (q0 > cprg_pkg::ONE_Q30) ? cprg_pkg::ONE_Q30 : q0;
    assign d1 = (q1 > cprg_pkg::ONE_Q30) ? cprg_pkg::ONE_Q30 : q1;
    assign d2 = (q2 > cprg_pkg::ONE_Q30) ? cprg_pkg::ONE_Q30 : q2;

    // Orthographic origin, rounded to Q16.16 with ties away from zero; it always fits.
    assign ox_prod = 40'(div_coord.xmag) * 40'(ortho_xmag_reg) + 40'd16384;
    assign oy_prod = 40'(div_coord.ymag) * 40'(ortho_ymag_reg) + 40'd16384;
    assign ox_mag  = 32'(ox_prod >> 15);
    assign oy_mag  = 32'(oy_prod >> 15);

    // Select the result for the projection mode and apply the signs.
    always_comb
    begin
        if (proj_mode_reg)
        begin
            origin_x_next = div_coord.xneg ? -ox_mag : ox_mag;
            origin_y_next = div_coord.yneg ? -oy_mag : oy_mag;
            dir_x_next    = 32'd0;
            dir_y_next    = 32'd0;
            dir_z_next    = -cprg_pkg::ONE_Q30;
        end
        else
        begin
            origin_x_next = 32'd0;
            origin_y_next = 32'd0;
            dir_x_next    = div_coord.xneg ? -{1'b0, d0} : {1'b0, d0};
            dir_y_next    = div_coord.yneg ? -{1'b0, d1} : {1'b0, d1};
            dir_z_next    = -d2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= div_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        origin_x_reg <= origin_x_next;
        origin_y_reg <= origin_y_next;
        dir_x_reg    <= dir_x_next;
        dir_y_reg    <= dir_y_next;
        dir_z_reg    <= dir_z_next;
    end

    assign done     = done_reg;
    assign origin_x = origin_x_reg;
    assign origin_y = origin_y_reg;
    assign origin_z = 1'b0;
    assign dir_x    = dir_x_reg;
    assign dir_y    = dir_y_reg;
    assign dir_z    = dir_z_reg;

`ifndef SYNTHESIS
    // Every result traces back to an accepted request.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, cprg_pkg::LATENCY))
        else $error("result without a matching request");

    // The z direction is strictly negative in both modes.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> dir_z[30])
        else $error("z direction not negative");

    // A perspective ray starts at the origin.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !proj_mode_reg) |-> (origin_x == 32'sd0 && origin_y == 32'sd0))
        else $error("perspective origin not zero");
`endif

endmodule

[tb/camera_primary_ray_gen_checker.sv]
// Checker for the ray generator: tracks registers, predicts every ray and compares results.
module camera_primary_ray_gen_checker (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic signed [15:0] screen_x,
    input  logic signed [15:0] screen_y,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [23:0]        cfg_data,
    input  logic               done,
    input  logic signed [31:0] origin_x,
    input  logic signed [31:0] origin_y,
    input  logic               origin_z,
    input  logic signed [31:0] dir_x,
    input  logic signed [31:0] dir_y,
    input  logic signed [30:0] dir_z,
    output int                 fail_count,
    output int                 rays_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [31:0] ox;
        logic [31:0] oy;
        logic        oz;
        logic [31:0] dx;
        logic [31:0] dy;
        logic [30:0] dz;
    } ray_t;

    // Shadow copy of the configuration registers.
    logic        ortho_mode;
    logic [23:0] tan_half_fov;
    logic [23:0] aspect;
    logic [23:0] xmag_gain;
    logic [23:0] ymag_gain;

    ray_t expected_rays[$];

    assign rays_pending = expected_rays.size();

    // Floor of the integer square root.
    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Sign and magnitude back to a two's complement field.
    function automatic logic [31:0] signed_field(logic neg, longint unsigned mag);
        longint unsigned v;
        v = neg ? (64'd0 - mag) : mag;
        return v[31:0];
    endfunction

    // Ray for one screen coordinate pair under the current registers.
    function automatic ray_t predict_ray(logic [15:0] sx, logic [15:0] sy);
        ray_t r;
        logic xneg;
        logic yneg;
        longint unsigned xm;
        longint unsigned ym;
        longint unsigned m[3];
        longint unsigned mx;
        longint unsigned sum;
        longint unsigned len;
        longint unsigned q;
        logic [31:0] zf;
        xneg = sx[15];
        yneg = sy[15];
        xm = xneg ? (64'h10000 - sx) : sx;
        ym = yneg ? (64'h10000 - sy) : sy;
        r = '0;
        if (ortho_mode) begin
            q = (xm * xmag_gain + (64'd1 << 14)) >> 15;
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            r.ox = signed_field(xneg, q);
            q = (ym * ymag_gain + (64'd1 << 14)) >> 15;
            if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
            r.oy = signed_field(yneg, q);
            zf = signed_field(1'b1, cprg_pkg::ONE_Q30);
            r.dz = zf[30:0];
            return r;
        end
        // Lateral terms and the unit z term at a common scale of 2^-47.
        m[0] = xm * tan_half_fov * aspect;
        m[1] = (ym * tan_half_fov) << 16;
        m[2] = 64'd1 << cprg_pkg::Z_TERM_BIT;
        mx = m[0];
        if (m[1] > mx) mx = m[1];
        if (m[2] > mx) mx = m[2];
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int k = 0; k < 3; k++)
                m[k] = m[k] >> 1;
        end
        sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
        len = int_sqrt(sum);
        if (len == 0) len = 1;
        for (int k = 0; k < 3; k++) begin
            q = ((m[k] << 30) + (len >> 1)) / len;
            if (q > cprg_pkg::ONE_Q30) q = cprg_pkg::ONE_Q30;
            m[k] = q;
        end
        r.dx = signed_field(xneg, m[0]);
        r.dy = signed_field(yneg, m[1]);
        zf = signed_field(1'b1, m[2]);
        r.dz = zf[30:0];
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // Register writes, request capture and result comparison.
    always @(posedge clk or negedge rst_n) begin
        ray_t want;
        if (!rst_n) begin
            ortho_mode   <= 1'b0;
            tan_half_fov <= 24'd65536;
            aspect       <= 24'd65536;
            xmag_gain    <= 24'd65536;
            ymag_gain    <= 24'd65536;
            expected_rays.delete();
            fail_count = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    cprg_pkg::REG_PROJ_MODE:    ortho_mode   <= cfg_data[0];
                    cprg_pkg::REG_HALF_FOV_TAN: tan_half_fov <= cfg_data;
                    cprg_pkg::REG_ASPECT:       aspect       <= cfg_data;
                    cprg_pkg::REG_ORTHO_XMAG:   xmag_gain    <= cfg_data;
                    cprg_pkg::REG_ORTHO_YMAG:   ymag_gain    <= cfg_data;
                    default: ;
                endcase
            end
            if (done) begin
                if (expected_rays.size() == 0) begin
                    report_mismatch("unexpected result", 32'd1, 32'd0);
                end else begin
                    want = expected_rays.pop_front();
                    if (origin_x !== want.ox) report_mismatch("origin_x", origin_x, want.ox);
                    if (origin_y !== want.oy) report_mismatch("origin_y", origin_y, want.oy);
                    if (origin_z !== want.oz)
                        report_mismatch("origin_z", {31'd0, origin_z}, {31'd0, want.oz});
                    if (dir_x !== want.dx) report_mismatch("dir_x", dir_x, want.dx);
                    if (dir_y !== want.dy) report_mismatch("dir_y", dir_y, want.dy);
                    if (dir_z !== want.dz)
                        report_mismatch("dir_z", {1'b0, dir_z}, {1'b0, want.dz});
                end
            end
            if (start && !busy)
                expected_rays.push_back(predict_ray(screen_x, screen_y));
        end
    end
endmodule

[tb/testbench.sv]
// Top of the ray generator testbench: clock, reset, stimulus, watchdog and verdict.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic signed [15:0] screen_x = '0;
    logic signed [15:0] screen_y = '0;
    logic               cfg_we = 1'b0;
    logic [2:0]         cfg_index = '0;
    logic [23:0]        cfg_data = '0;
    logic               done;
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic               origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [30:0] dir_z;
    int                 fail_count;
    int                 rays_pending;
    int                 quiet_cycles = 0;
    bit                 no_gaps = 0;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    camera_primary_ray_gen_core DUT (.*);

    camera_primary_ray_gen_checker checker_inst (.*);

    // Abort when nothing has moved for too long.
    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT)
        begin
            $display("camera_primary_ray_gen_core regression: fail");
            $finish;
        end
    end

    // Mostly short gaps, a few long ones.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (no_gaps || p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(4, 40);
    endfunction

    // Present one request and hold it until accepted.
    task automatic send_request(logic [15:0] sx, logic [15:0] sy);
        bit taken;
        int gap;
        start    <= 1'b1;
        screen_x <= sx;
        screen_y <= sy;
        forever
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
            if (taken) break;
        end
        gap = pick_gap();
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Drain, then write all registers plus one unused index.
    task automatic load_camera(logic mode, logic [23:0] t, logic [23:0] a,
                               logic [23:0] xg, logic [23:0] yg);
        logic [23:0] vals[5];
        vals = '{{23'd0, mode}, t, a, xg, yg};
        if (start)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        while (rays_pending != 0) @(posedge clk);
        for (int i = 0; i < 5; i++)
        begin
            cfg_we    <= 1'b1;
            cfg_index <= i[2:0];
            cfg_data  <= (i == 0) ? {23'($urandom_range(0, 8388607)), mode} : vals[i];
            @(posedge clk);
        end
        cfg_index <= 3'($urandom_range(5, 7));
        cfg_data  <= 24'($urandom);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            send_request(16'($urandom), 16'($urandom));
    endtask

    initial
    begin
        logic [15:0] edges[6];
        edges = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF, 16'h4000};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: coordinate extremes under reset values, then in both modes.
        for (int i = 0; i < 6; i++)
            send_request(edges[i], edges[5 - i]);
        send_request(16'h8000, 16'h8000);
        send_request(16'h7FFF, 16'h7FFF);
        load_camera(1'b1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
        for (int i = 0; i < 6; i++)
            send_request(edges[i], edges[i]);
        load_camera(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'd0, 24'd0);
        for (int i = 0; i < 4; i++)
            send_request(edges[i], edges[3 - i]);
        // Zero tangent, zero aspect, then zero orthographic gains.
        load_camera(1'b0, 24'd0, 24'd65536, 24'd1, 24'd1);
        send_request(16'h8000, 16'h7FFF);
        load_camera(1'b0, 24'd65536, 24'd0, 24'd1, 24'd1);
        send_request(16'h8000, 16'h7FFF);
        load_camera(1'b1, 24'd0, 24'd0, 24'd0, 24'd0);
        send_request(16'h8000, 16'h7FFF);

        // Random: ten settings, some at the extremes, some without gaps.
        for (int ph = 0; ph < 10; ph++)
        begin
            no_gaps = ($urandom_range(0, 3) == 0);
            if (ph == 0)
                load_camera(1'b0, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
            else if (ph == 1)
                load_camera(1'b1, 24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'hFFFFFF);
            else if (ph < 6)
                load_camera(ph[0], 24'($urandom_range(0, 262143)),
                            24'($urandom_range(0, 262143)),
                            24'($urandom_range(0, 262143)),
                            24'($urandom_range(0, 262143)));
            else
                load_camera(ph[0], 24'($urandom), 24'($urandom), 24'($urandom),
                            24'($urandom));
            random_phase(128);
        end
        start <= 1'b0;

        // Drain and let the pipeline settle.
        while (rays_pending != 0) @(posedge clk);
        repeat (cprg_pkg::LATENCY + 8) @(posedge clk);
        if (fail_count == 0)
            $display("camera_primary_ray_gen_core regression: pass");
        else
            $display("camera_primary_ray_gen_core regression: fail");
        $finish;
    end
endmodule
